/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check, masked while reset is asserted
`define CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent check, active during reset too
`define CHK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* design/hlhg_pkg.sv */
package hlhg_pkg;

  // sizes
  localparam int MAX_LEAVES_DEF = 32;
  localparam int SEED_W     = 30;
  localparam int VAL_W      = 33;
  localparam int BCD_DIG    = 10;
  localparam int BCD_W      = 4 * BCD_DIG;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 30;
  localparam int BLK_W      = 512;
  localparam int DIG_W      = 256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LPE    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCHS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LPS    = 4'd3;

  // register reset values
  localparam logic [SEED_W-1:0] SEED_RST   = '0;
  localparam logic [15:0]       LPE_RST    = 16'd256;
  localparam logic [15:0]       EPOCHS_RST = 16'd1;
  localparam logic [5:0]        LPS_RST    = 6'd32;

  // request function codes
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_SIGN = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] message;
    logic [15:0]        epoch;
    logic [31:0]        key_index;
  } in_t;

  typedef struct packed {
    logic [15:0] leaf_index;
    logic [63:0] leaf_word0;
    logic [63:0] leaf_word1;
    logic [63:0] leaf_word2;
    logic [63:0] leaf_word3;
    logic        aborted;
    logic        last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ABORT, S_CONV, S_HASH1, S_HASH2A, S_HASH2B, S_LEAF
  } state_t;

  typedef struct packed {
    logic start;
    logic init;
  } sha_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sha_stat_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // second block of a 64-byte message: marker bit and 512-bit length
  localparam logic [BLK_W-1:0] PAD_BLOCK = {8'h80, 488'd0, 16'h0200};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // padded single block holding the decimal text, optional leading minus
  function automatic logic [BLK_W-1:0] text_block(input logic [BCD_W-1:0] bcd,
                                                  input logic neg);
    logic [BLK_W-1:0] blk;
    logic [3:0]       ndig;
    logic [3:0]       len;
    int               d;
    blk  = '0;
    ndig = 4'd1;
    d    = 0;
    for (int i = 1; i < BCD_DIG; i++) begin
      if (bcd[4*i +: 4] != 4'd0) ndig = 4'(i + 1);
    end
    len = ndig + {3'b000, neg};
    for (int p = 0; p < 16; p++) begin
      if (neg && p == 0) begin
        blk[BLK_W-1-8*p -: 8] = 8'h2d;
      end else if (p < int'(len)) begin
        d = int'(len) - 1 - p;
        blk[BLK_W-1-8*p -: 8] = 8'h30 + {4'h0, bcd[4*d +: 4]};
      end else if (p == int'(len)) begin
        blk[BLK_W-1-8*p -: 8] = 8'h80;
      end
    end
    blk[7:0] = {1'b0, len, 3'b000};
    return blk;
  endfunction

  // lowercase hex text of a digest, exactly one block
  function automatic logic [BLK_W-1:0] hex_block(input logic [DIG_W-1:0] dg);
    logic [BLK_W-1:0] blk;
    logic [7:0]       b;
    logic [3:0]       hi;
    logic [3:0]       lo;
    blk = '0;
    for (int i = 0; i < 32; i++) begin
      b  = dg[DIG_W-1-8*i -: 8];
      hi = b[7:4];
      lo = b[3:0];
      blk[BLK_W-1-16*i -: 8] = (hi < 4'd10) ? (8'h30 + {4'h0, hi}) : (8'h57 + {4'h0, hi});
      blk[BLK_W-9-16*i -: 8] = (lo < 4'd10) ? (8'h30 + {4'h0, lo}) : (8'h57 + {4'h0, lo});
    end
    return blk;
  endfunction

endpackage

/* design/hlhg_bcd_conv.sv */
module hlhg_bcd_conv
  import hlhg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] value,
  output logic [BCD_W-1:0] bcd,
  output logic             done
);

  logic [VAL_W-1:0] bin_r;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] adj;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIG; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3) : bcd_r[4*i +: 4];
    end
  end

  // one input bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(VAL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= value;
      bcd_r <= '0;
    end else if (busy_r) begin
      bcd_r <= {adj[BCD_W-2:0], bin_r[VAL_W-1]};
      bin_r <= {bin_r[VAL_W-2:0], 1'b0};
    end
  end

  assign bcd  = bcd_r;
  assign done = done_r;

endmodule

/* design/hlhg_sha_core.sv */
module hlhg_sha_core
  import hlhg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  sha_ctl_t         ctl,
  input  logic [BLK_W-1:0] blk,
  output sha_stat_t        stat,
  output logic [DIG_W-1:0] digest
);

`include "assert_macros.svh"

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r;
  logic        busy_r;
  logic        fin_r;
  logic        done_r;

  logic [31:0] big_s1, ch, t1, big_s0, maj, t2, sm_s0, sm_s1, w_new;

  // one round of the compression function
  always_comb begin
    big_s1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1     = v_r[7] + big_s1 + ch + sha_k(rnd_r) + w_r[0];
    big_s0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2     = big_s0 + maj;
    sm_s0  = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    sm_s1  = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new  = sm_s1 + w_r[9] + sm_s0 + w_r[0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) fin_r <= 1'b1;
      end
    end
  end

  // working store
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk[BLK_W-1-32*i -: 32];
      for (int i = 0; i < 8; i++) begin
        if (ctl.init) begin
          h_r[i] <= SHA_IV[i];
          v_r[i] <= SHA_IV[i];
        end else begin
          v_r[i] <= h_r[i];
        end
      end
    end else if (fin_r) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7]  <= v_r[6];
      v_r[6]  <= v_r[5];
      v_r[5]  <= v_r[4];
      v_r[4]  <= v_r[3] + t1;
      v_r[3]  <= v_r[2];
      v_r[2]  <= v_r[1];
      v_r[1]  <= v_r[0];
      v_r[0]  <= t1 + t2;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4], h_r[5], h_r[6], h_r[7]};

  `CHK_RST(a_start_when_idle, ctl.start |-> !busy_r, "block started while core busy")

endmodule

/* design/hors_leaf_hash_generator.sv */
// A key request gives its leaf after a decimal conversion and three SHA-256 compressions;
// a sign request first hashes the message (decimal conversion plus one compression),
// then gives each leaf after a decimal conversion plus three SHA-256 compressions at one
// round per cycle. An abort result appears in the cycle after acceptance.
// busy stays high until the last result is out; results cannot be stalled.
// Synchronous active-low reset returns to idle and reloads register defaults.
module hors_leaf_hash_generator
  import hlhg_pkg::*;
#(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   in_req,
  output logic                  out_valid,
  output out_t                  out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

  localparam int CW = $clog2(MAX_LEAVES + 1);

  // configuration
  logic [SEED_W-1:0] seed_r;
  logic [15:0]       lpe_r;
  logic [15:0]       epochs_r;
  logic [5:0]        lps_r;

  state_t            state_r, state_nxt;
  logic              sign_r, sign_nxt;
  logic              msg_phase_r, msg_phase_nxt;
  logic              neg_r, neg_nxt;
  logic [15:0]       base_r, base_nxt;
  logic [CW-1:0]     leaf_cnt_r, leaf_cnt_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [15:0]       leaf_idx_r, leaf_idx_nxt;
  logic [DIG_W-1:0]  md_r, md_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              accept, abort, is_last;
  logic [CW-1:0]     k_w;
  logic [31:0]       mag;
  logic [4:0]        jsel;
  logic [15:0]       idx;

  logic              conv_start;
  logic [VAL_W-1:0]  conv_val;
  logic [BCD_W-1:0]  bcd;
  logic              conv_done;
  sha_ctl_t          sha_ctl;
  sha_stat_t         sha_stat;
  logic [BLK_W-1:0]  sha_blk;
  logic [DIG_W-1:0]  digest;

  hlhg_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .value (conv_val),
    .bcd   (bcd),
    .done  (conv_done)
  );

  hlhg_sha_core u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sha_ctl),
    .blk    (sha_blk),
    .stat   (sha_stat),
    .digest (digest)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= SEED_RST;
      lpe_r    <= LPE_RST;
      epochs_r <= EPOCHS_RST;
      lps_r    <= LPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED:   seed_r   <= cfg_wdata[SEED_W-1:0];
        CFG_LPE:    lpe_r    <= cfg_wdata[15:0];
        CFG_EPOCHS: epochs_r <= cfg_wdata[15:0];
        CFG_LPS:    lps_r    <= cfg_wdata[5:0];
        default:    ;
      endcase
    end
  end

  // request decode
  assign accept  = start && (state_r == S_IDLE);
  assign abort   = (in_req.func == FUNC_SIGN) && (in_req.epoch > epochs_r);
  assign k_w     = (int'(lps_r) > MAX_LEAVES) ? CW'(MAX_LEAVES) : CW'(lps_r);
  assign mag     = in_req.message[31] ? (32'd0 - 32'(in_req.message)) : 32'(in_req.message);
  assign is_last = !sign_r || (CW'(leaf_cnt_r + 1'b1) == k_r);
  assign jsel    = 5'(leaf_cnt_r);
  assign idx     = base_r + md_r[{jsel, 3'b000} +: 8];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.func == FUNC_KEY) state_nxt = S_CONV;
          else if (abort)              state_nxt = S_ABORT;
          else if (k_w != '0)          state_nxt = S_CONV;
        end
      end
      S_ABORT:  state_nxt = S_IDLE;
      S_CONV:   if (conv_done) state_nxt = S_HASH1;
      S_HASH1:  if (sha_stat.done) state_nxt = msg_phase_r ? S_LEAF : S_HASH2A;
      S_HASH2A: if (sha_stat.done) state_nxt = S_HASH2B;
      S_HASH2B: if (sha_stat.done) state_nxt = is_last ? S_IDLE : S_LEAF;
      S_LEAF:   state_nxt = S_CONV;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and unit control
  always_comb begin
    sign_nxt      = sign_r;
    msg_phase_nxt = msg_phase_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    leaf_cnt_nxt  = leaf_cnt_r;
    k_nxt         = k_r;
    leaf_idx_nxt  = leaf_idx_r;
    md_nxt        = md_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    conv_start    = 1'b0;
    conv_val      = '0;
    sha_ctl       = '0;
    sha_blk       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sign_nxt     = in_req.func;
          leaf_cnt_nxt = '0;
          k_nxt        = k_w;
          base_nxt     = (in_req.epoch - 16'd1) * lpe_r;
          if (in_req.func == FUNC_KEY) begin
            conv_start    = 1'b1;
            conv_val      = {1'b0, 2'b00, seed_r} + {1'b0, in_req.key_index};
            neg_nxt       = 1'b0;
            msg_phase_nxt = 1'b0;
            leaf_idx_nxt  = in_req.key_index[15:0];
          end else if (abort) begin
            out_valid_nxt   = 1'b1;
            out_nxt         = '0;
            out_nxt.aborted = 1'b1;
            out_nxt.last    = 1'b1;
          end else if (k_w != '0) begin
            conv_start    = 1'b1;
            conv_val      = {1'b0, mag};
            neg_nxt       = in_req.message[31];
            msg_phase_nxt = 1'b1;
          end
        end
      end
      S_CONV: begin
        if (conv_done) begin
          sha_ctl.start = 1'b1;
          sha_ctl.init  = 1'b1;
          sha_blk       = text_block(bcd, neg_r);
        end
      end
      S_HASH1: begin
        if (sha_stat.done) begin
          if (msg_phase_r) begin
            md_nxt        = digest;
            msg_phase_nxt = 1'b0;
          end else begin
            sha_ctl.start = 1'b1;
            sha_ctl.init  = 1'b1;
            sha_blk       = hex_block(digest);
          end
        end
      end
      S_HASH2A: begin
        if (sha_stat.done) begin
          sha_ctl.start = 1'b1;
          sha_ctl.init  = 1'b0;
          sha_blk       = PAD_BLOCK;
        end
      end
      S_HASH2B: begin
        if (sha_stat.done) begin
          out_valid_nxt = 1'b1;
          out_nxt       = {leaf_idx_r, digest, 1'b0, is_last};
          leaf_cnt_nxt  = CW'(leaf_cnt_r + 1'b1);
        end
      end
      S_LEAF: begin
        conv_start   = 1'b1;
        conv_val     = {3'b000, seed_r} + {17'd0, idx};
        neg_nxt      = 1'b0;
        leaf_idx_nxt = idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      leaf_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      leaf_cnt_r  <= leaf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r      <= sign_nxt;
    msg_phase_r <= msg_phase_nxt;
    neg_r       <= neg_nxt;
    base_r      <= base_nxt;
    k_r         <= k_nxt;
    leaf_idx_r  <= leaf_idx_nxt;
    md_r        <= md_nxt;
    out_r       <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  `CHK_RST(a_abort_form, out_valid |-> (!out_rsp.aborted || (out_rsp.last && out_rsp.leaf_index == 16'd0)), "malformed abort result")
  `CHK_RST(a_leaf_bound, (state_r == S_LEAF) |-> (leaf_cnt_r < k_r), "leaf count past k")
  `CHK_RST(a_sha_idle, (state_r == S_IDLE) |-> !sha_stat.busy, "hash core busy while idle")
  `CHK_ALL(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "not idle after reset")

endmodule
